@@ rtl/itoar_pkg.sv @@
package itoar_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IN_WIDTH        = 32;
	localparam int RADIX_WIDTH     = 6;

	localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_WIDTH-1:0] RADIX_DEC = 6'd10;

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_A     = 8'h61;
	localparam logic [7:0] CHR_MINUS = 8'h2d;

	typedef struct packed {
		logic                   op;
		logic [IN_WIDTH-1:0]    value_bits;
		logic [RADIX_WIDTH-1:0] radix;
	} num_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} txt_t;

	function automatic logic [7:0] char_of_digit(input logic [RADIX_WIDTH-1:0] d);
		logic [7:0] dw;
		dw = {2'b00, d};
		if (d > 6'd9) begin
			char_of_digit = CHR_A - 8'd10 + dw;
		end else begin
			char_of_digit = CHR_ZERO + dw;
		end
	endfunction

endpackage

@@ rtl/integer_to_ascii_radix_unit.sv @@
// Integer to ASCII conversion, radix 2 to 36, most significant character first.
// Input channel num (num_valid / num_stall / num): one word per number, taking op,
// value_bits and radix. op = 1 is unsigned decimal; op = 0 uses radix (clamped to
// 2..36), and in radix 10 a negative value comes out as '-' and its magnitude.
// Output channel txt (txt_valid / txt_stall / txt): one word per character, last
// set on the final one. No terminating NUL.
// The value is divided by the radix with a restoring long division, one quotient
// bit per cycle; digits are held on a shift stack and emitted from the output
// register one per cycle while txt is not stalled.
// Digits per number with VALUE_WIDTH = 32: up to 10 in radix 10, up to 32 in radix 2.
// One number is converted at a time; num_stall is high from acceptance until the
// last character has been loaded into the output register.
// A stall on txt holds the output word and pauses emission; division carries on.
// Reset (arst_n low) empties the block and drops any word in flight.
module integer_to_ascii_radix_unit #(
	parameter int VALUE_WIDTH = itoar_pkg::VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             num_valid,
	output logic             num_stall,
	input  itoar_pkg::num_t  num,
	output logic             txt_valid,
	input  logic             txt_stall,
	output itoar_pkg::txt_t  txt
);

	localparam int BW = $clog2(VALUE_WIDTH);
	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int RW = itoar_pkg::RADIX_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_MINUS = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [RW-1:0]        radix_q;
	logic [RW-1:0]        rem_q;
	logic                 nz_q;
	logic                 minus_q;
	logic [BW-1:0]        bit_q;
	logic [CW-1:0]        cnt_q;
	logic [RW-1:0]        stk_q [VALUE_WIDTH];
	logic                 txt_valid_q;
	itoar_pkg::txt_t      txt_q;

	logic                   accept;
	logic                   slot_free;
	logic                   txt_load;
	logic [RW-1:0]          base;
	logic [VALUE_WIDTH-1:0] v_in;
	logic                   neg;
	logic [RW:0]            trial;
	logic                   qbit;
	logic [RW-1:0]          rem_nx;
	logic                   nz_nx;
	logic                   digit_done;

	assign num_stall = (state_q != ST_IDLE);
	assign accept    = num_valid && (state_q == ST_IDLE);
	assign slot_free = !txt_valid_q || !txt_stall;
	assign txt_load  = slot_free && ((state_q == ST_MINUS) || (state_q == ST_EMIT));
	assign txt_valid = txt_valid_q;
	assign txt       = txt_q;

	always_comb begin
		if (num.op) begin
			base = itoar_pkg::RADIX_DEC;
		end else if (num.radix < itoar_pkg::RADIX_MIN) begin
			base = itoar_pkg::RADIX_MIN;
		end else if (num.radix > itoar_pkg::RADIX_MAX) begin
			base = itoar_pkg::RADIX_MAX;
		end else begin
			base = num.radix;
		end
		v_in = VALUE_WIDTH'(num.value_bits);
		neg  = !num.op && (base == itoar_pkg::RADIX_DEC) && v_in[VALUE_WIDTH-1];
	end

	// restoring division step
	always_comb begin
		trial = {rem_q, quo_q[VALUE_WIDTH-1]};
		qbit  = (trial >= {1'b0, radix_q});
		if (qbit) begin
			rem_nx = RW'(trial - {1'b0, radix_q});
		end else begin
			rem_nx = trial[RW-1:0];
		end
		nz_nx      = nz_q || qbit;
		digit_done = (bit_q == BW'(VALUE_WIDTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			bit_q       <= '0;
			txt_valid_q <= 1'b0;
		end else begin
			if (txt_load) begin
				txt_valid_q <= 1'b1;
			end else if (!txt_stall) begin
				txt_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						bit_q   <= '0;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						bit_q <= '0;
						cnt_q <= cnt_q + CW'(1);
						if (!nz_nx) begin
							state_q <= minus_q ? ST_MINUS : ST_EMIT;
						end
					end else begin
						bit_q <= bit_q + BW'(1);
					end
				end
				ST_MINUS: begin
					if (slot_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					quo_q   <= neg ? (~v_in + VALUE_WIDTH'(1)) : v_in;
					radix_q <= base;
					minus_q <= neg;
					rem_q   <= '0;
					nz_q    <= 1'b0;
				end
			end
			ST_DIV: begin
				quo_q <= {quo_q[VALUE_WIDTH-2:0], qbit};
				if (digit_done) begin
					rem_q    <= '0;
					nz_q     <= 1'b0;
					stk_q[0] <= rem_nx;
					for (int i = 1; i < VALUE_WIDTH; i++) begin
						stk_q[i] <= stk_q[i-1];
					end
				end else begin
					rem_q <= rem_nx;
					nz_q  <= nz_nx;
				end
			end
			ST_MINUS: begin
				if (slot_free) begin
					txt_q.character <= itoar_pkg::CHR_MINUS;
					txt_q.last      <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					txt_q.character <= itoar_pkg::char_of_digit(stk_q[0]);
					txt_q.last      <= (cnt_q == CW'(1));
					for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
						stk_q[i] <= stk_q[i+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
